// ===== hw/rtl/met_pkg.sv =====
package met_pkg;

   // Fixed point: FRAC_BITS fraction bits; z and c need four integer bits and a sign.
   localparam int FRAC_BITS = 26;
   localparam int ZW = FRAC_BITS + 5;
   // Multiplier operand: |x|, |y| < 2 and |2x| < 4 once the bound test has passed.
   localparam int MW = FRAC_BITS + 3;
   // Dividend of the coordinate mapping: px * 7 * 2^(FRAC_BITS-1).
   localparam int NW = FRAC_BITS + 14;
   localparam int CW = $clog2(NW + 1);

   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_MAX_ITER = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_WIDTH    = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_HEIGHT   = 2'd2;

   localparam logic [15:0] MAX_ITER_RESET = 16'd10000;
   localparam logic [12:0] WIDTH_RESET    = 13'd1920;
   localparam logic [12:0] HEIGHT_RESET   = 13'd1080;

   localparam logic [NW-1:0] OFFSET_X = NW'(5) << (FRAC_BITS - 1);
   localparam logic [NW-1:0] OFFSET_Y = NW'(1) << FRAC_BITS;
   localparam logic [NW-1:0] C_SPAN   = NW'(8) << FRAC_BITS;
   localparam logic [NW-1:0] LIMIT_X  = OFFSET_X + C_SPAN;
   localparam logic [NW-1:0] LIMIT_Y  = OFFSET_Y + C_SPAN;

   localparam logic signed [ZW-1:0] C_MAX       = (ZW'(1) << (FRAC_BITS + 3)) - ZW'(1);
   localparam logic signed [ZW-1:0] Z_LIMIT     = ZW'(2) << FRAC_BITS;
   localparam logic signed [ZW-1:0] Z_LIMIT_NEG = -(ZW'(2) << FRAC_BITS);
   localparam logic signed [ZW-1:0] FOUR_FX     = ZW'(4) << FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y,
      ST_CHECK,
      ST_MUL_YY,
      ST_MUL_XY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic            start;
      logic [NW-1:0]   num;
      logic [12:0]     den;
   } div_req_type;

endpackage

// ===== hw/rtl/met_div.sv =====
module met_div
   import met_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  div_req_type   req,
   output logic          done,
   output logic [NW-1:0] quotient
);

   logic [NW-1:0] quo_ff, quo_in;
   logic [12:0]   rem_ff, rem_in;
   logic [12:0]   den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [13:0]   shifted;
   logic          fits;

   // One quotient bit a step: shift the next dividend bit into the remainder.
   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? 13'(shifted - {1'b0, den_ff}) : shifted[12:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/mandelbrot_escape_time_unit.sv =====
// Channel   | Direction | Signals                                         | Accepted when
// ----------+-----------+-------------------------------------------------+----------------------
// request   | in        | req_valid/req_ready, req_pixel_x/y, req_last_in_tile | valid & ready
// response  | out       | rsp_valid/rsp_ready, rsp_iteration_count, rsp_tile_end | valid & ready
// csr       | in        | csr_wr_en, csr_index, csr_wdata                 | csr_wr_en
//
// Each item runs two bit-serial divisions of FRAC_BITS+14 steps each, then, per iteration,
// the states ST_CHECK, ST_MUL_YY and ST_MUL_XY on the single shared multiplier (x*x, y*y,
// 2x*y); it ends on the bound or limit test or on the squared-magnitude test. The next item
// is taken only once this one has left ST_DONE. req_ready is high only while idle.
// A finished item waits in the response register; the next item is taken meanwhile.
// Reset is synchronous and restores the registers to 10000 / 1920 / 1080.
module mandelbrot_escape_time_unit
   import met_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [11:0]       req_pixel_x,
   input  logic [11:0]       req_pixel_y,
   input  logic              req_last_in_tile,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_iteration_count,
   output logic              rsp_tile_end,
   input  logic              csr_wr_en,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [15:0]       csr_wdata
);

   state_type state_ff, state_in;

   logic [15:0] max_iter_ff;
   logic [12:0] width_ff, height_ff;

   logic [11:0]            py_ff;
   logic                   mark_ff;
   logic signed [ZW-1:0]   x_ff, y_ff, xx_ff, yy_ff, cx_ff, cy_ff;
   logic [15:0]            count_ff;
   logic                   rsp_valid_ff;
   logic [15:0]            rsp_count_ff;
   logic                   rsp_tile_end_ff;

   div_req_type            div_req;
   logic                   div_done;
   logic [NW-1:0]          div_q;

   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] prod, prod_sh;
   logic signed [ZW-1:0]   mul_res;

   logic [14:0]            px7;
   logic [12:0]            den_x, den_y;
   logic signed [ZW-1:0]   cx_new, cy_new;
   logic                   out_free, out_bound, escaped, at_limit;

   met_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   assign px7   = {req_pixel_x, 3'b000} - {3'b000, req_pixel_x};
   assign den_x = (width_ff == 13'd0) ? 13'd1 : width_ff;
   assign den_y = (height_ff == 13'd0) ? 13'd1 : height_ff;

   // Quotient is never negative, so only the top of the plane needs saturating.
   assign cx_new = (div_q >= LIMIT_X) ? C_MAX : ZW'(div_q - OFFSET_X);
   assign cy_new = (div_q >= LIMIT_Y) ? C_MAX : ZW'(div_q - OFFSET_Y);

   // Shared multiplier; an arithmetic shift of the exact product floors it.
   assign prod    = mul_a * mul_b;
   assign prod_sh = prod >>> FRAC_BITS;
   assign mul_res = prod_sh[ZW-1:0];

   assign out_bound = (x_ff >= Z_LIMIT) || (x_ff <= Z_LIMIT_NEG) ||
                      (y_ff >= Z_LIMIT) || (y_ff <= Z_LIMIT_NEG);
   assign at_limit  = count_ff >= max_iter_ff;
   assign escaped   = (xx_ff + yy_ff) >= FOUR_FX;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DIV_X;
         ST_DIV_X:  if (div_done) state_in = ST_DIV_Y;
         ST_DIV_Y:  if (div_done) state_in = ST_CHECK;
         ST_CHECK:  state_in = (at_limit || out_bound) ? ST_DONE : ST_MUL_YY;
         ST_MUL_YY: state_in = ST_MUL_XY;
         ST_MUL_XY: state_in = escaped ? ST_DONE : ST_CHECK;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = {px7, {(FRAC_BITS - 1){1'b0}}};
      div_req.den   = den_x;
      mul_a         = x_ff[MW-1:0];
      mul_b         = x_ff[MW-1:0];
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            div_req.start = req_valid;
         end
         ST_DIV_X: begin
            div_req.start = div_done;
            div_req.num   = {1'b0, py_ff, {(FRAC_BITS + 1){1'b0}}};
            div_req.den   = den_y;
         end
         ST_MUL_YY: begin
            mul_a = y_ff[MW-1:0];
            mul_b = y_ff[MW-1:0];
         end
         ST_MUL_XY: begin
            mul_a = {x_ff[MW-2:0], 1'b0};
            mul_b = y_ff[MW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_iter_ff  <= MAX_ITER_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAX_ITER: max_iter_ff <= csr_wdata;
               CSR_WIDTH:    width_ff    <= csr_wdata[12:0];
               CSR_HEIGHT:   height_ff   <= csr_wdata[12:0];
               default: ;
            endcase
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            py_ff   <= req_pixel_y;
            mark_ff <= req_last_in_tile;
         end
         ST_DIV_X: begin
            if (div_done) cx_ff <= cx_new;
         end
         ST_DIV_Y: begin
            if (div_done) begin
               cy_ff    <= cy_new;
               x_ff     <= '0;
               y_ff     <= '0;
               count_ff <= '0;
            end
         end
         ST_CHECK: xx_ff <= mul_res;
         ST_MUL_YY: yy_ff <= mul_res;
         ST_MUL_XY: begin
            // Commit the step only if the point is still inside.
            if (!escaped) begin
               x_ff     <= xx_ff - yy_ff + cx_ff;
               y_ff     <= mul_res + cy_ff;
               count_ff <= count_ff + 16'd1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_count_ff    <= count_ff;
               rsp_tile_end_ff <= mark_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_tile_end        = rsp_tile_end_ff;

endmodule

// ===== bench/mandelbrot_escape_time_unit_tb.sv =====
`timescale 1ns / 100ps

module mandelbrot_escape_time_unit_tb
   import met_pkg::*;
();

   localparam int LONG_HOLD      = 600;
   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int DRAIN_CYCLES   = 200;

   localparam longint C_HIGH    = (longint'(8) << FRAC_BITS) - 1;
   localparam longint C_LOW     = -(longint'(8) << FRAC_BITS);
   localparam longint Z_BOUND   = longint'(2) << FRAC_BITS;
   localparam longint ESCAPE_R2 = longint'(4) << FRAC_BITS;
   localparam longint HALF_ONE  = longint'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic [15:0] count;
      logic        tile_end;
   } pixel_result_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [11:0]       req_pixel_x;
   logic [11:0]       req_pixel_y;
   logic              req_last_in_tile;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [15:0]       rsp_iteration_count;
   logic              rsp_tile_end;
   logic              csr_wr_en;
   logic [CSR_IW-1:0] csr_index;
   logic [15:0]       csr_wdata;

   // register copies, used by the escape predictor
   logic [15:0] cfg_max_iter = MAX_ITER_RESET;
   logic [12:0] cfg_width    = WIDTH_RESET;
   logic [12:0] cfg_height   = HEIGHT_RESET;

   pixel_result_type expected_escapes[$];

   int  error_count   = 0;
   int  pixels_sent   = 0;
   int  results_seen  = 0;
   int  settings_used = 1;
   int  deepest_count = 0;
   int  hold_left     = 0;
   int  idle_cycles   = 0;
   bit  no_gaps       = 1'b0;
   bit  long_hold_req = 1'b0;

   mandelbrot_escape_time_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_x        (req_pixel_x),
      .req_pixel_y        (req_pixel_y),
      .req_last_in_tile   (req_last_in_tile),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_iteration_count(rsp_iteration_count),
      .rsp_tile_end       (rsp_tile_end),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // floor(a*b / 2^FRAC_BITS); operands stay inside 29 bits
   function automatic longint fx_mul(input longint a, input longint b);
      return (a * b) >>> FRAC_BITS;
   endfunction

   function automatic longint clamp_c(input longint v);
      if (v < C_LOW) return C_LOW;
      if (v > C_HIGH) return C_HIGH;
      return v;
   endfunction

   function automatic logic [15:0] escape_count(input logic [11:0] px, input logic [11:0] py);
      longint      w, h, cx, cy, x, y, xx, yy, xt;
      int unsigned n;
      w  = (cfg_width == 0) ? 64'sd1 : longint'(cfg_width);
      h  = (cfg_height == 0) ? 64'sd1 : longint'(cfg_height);
      cx = clamp_c((longint'(px) * 7 * HALF_ONE) / w - 5 * HALF_ONE);
      cy = clamp_c((longint'(py) << (FRAC_BITS + 1)) / h - (longint'(1) << FRAC_BITS));
      x  = 0;
      y  = 0;
      n  = 0;
      while (n < cfg_max_iter) begin
         if (x >= Z_BOUND || x <= -Z_BOUND || y >= Z_BOUND || y <= -Z_BOUND) break;
         xx = fx_mul(x, x);
         yy = fx_mul(y, y);
         if (xx + yy >= ESCAPE_R2) break;
         xt = xx - yy + cx;
         y  = fx_mul(2 * x, y) + cy;
         x  = xt;
         n++;
      end
      return n[15:0];
   endfunction

   function automatic logic [12:0] pick_extent();
      case ($urandom_range(0, 9))
         0: begin
            return 13'd1;
         end
         1: begin
            return 13'd4096;
         end
         2: begin
            return 13'd8191;
         end
         default: begin
            return 13'($urandom_range(1, 4096));
         end
      endcase
   endfunction

   task automatic send_pixel(input logic [11:0] px, input logic [11:0] py, input logic tile_last);
      int               gap;
      pixel_result_type want;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel_x      <= px;
      req_pixel_y      <= py;
      req_last_in_tile <= tile_last;
      do @(posedge clock); while (!req_ready);
      want.count    = escape_count(px, py);
      want.tile_end = tile_last;
      expected_escapes.push_back(want);
      pixels_sent++;
   endtask

   task automatic drain_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_escapes.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IW-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MAX_ITER: begin
            cfg_max_iter = value;
         end
         CSR_WIDTH: begin
            cfg_width = value[12:0];
         end
         CSR_HEIGHT: begin
            cfg_height = value[12:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] lim, input logic [12:0] w, input logic [12:0] h);
      drain_results();
      write_csr(CSR_MAX_ITER, lim);
      write_csr(CSR_WIDTH, 16'(w));
      write_csr(CSR_HEIGHT, 16'(h));
      settings_used++;
   endtask

   task automatic test_reset_defaults;
      send_pixel(12'd0, 12'd0, 1'b0);        // c = (-2.5, -1): out after one iteration
      send_pixel(12'd1371, 12'd540, 1'b0);   // just left of the origin: runs to the limit
      send_pixel(12'd1919, 12'd1079, 1'b1);
   endtask

   task automatic test_field_extremes;
      configure(16'd255, 13'd4096, 13'd4096);
      send_pixel(12'd0, 12'd0, 1'b0);
      send_pixel(12'd4095, 12'd4095, 1'b1);
      send_pixel(12'hAAA, 12'h555, 1'b0);
      send_pixel(12'h555, 12'hAAA, 1'b1);
      send_pixel(12'd4095, 12'd0, 1'b0);
      send_pixel(12'd0, 12'd4095, 1'b1);
      // pixel x 4095 lies far off the plane and saturates the real part; pixel x 0 does not
      configure(16'd255, 13'd1, 13'd8191);
      send_pixel(12'd4095, 12'd4095, 1'b0);
      send_pixel(12'd0, 12'd4095, 1'b1);
   endtask

   task automatic test_zero_divisor;
      configure(16'd100, 13'd0, 13'd0);
      send_pixel(12'd0, 12'd0, 1'b0);
      send_pixel(12'd1, 12'd1, 1'b1);
      send_pixel(12'd3, 12'd0, 1'b0);
   endtask

   task automatic test_zero_limit;
      configure(16'd0, 13'd7, 13'd2);
      send_pixel(12'd5, 12'd1, 1'b1);        // c = 0, still no iterations
      send_pixel(12'd0, 12'd0, 1'b0);
   endtask

   task automatic test_limit_extremes;
      configure(16'd1, 13'd7, 13'd2);
      send_pixel(12'd5, 12'd1, 1'b0);
      configure(16'd65535, 13'd7, 13'd2);
      send_pixel(12'd5, 12'd1, 1'b1);        // c = 0: full 65535 iterations
      send_pixel(12'd4095, 12'd4095, 1'b0);
   endtask

   task automatic test_output_stall;
      int i;
      configure(16'd40, 13'd64, 13'd64);
      @(posedge clock);
      long_hold_req = 1'b1;
      no_gaps       = 1'b1;
      for (i = 0; i < 6; i++) begin
         send_pixel(12'(i * 9), 12'd32, i == 5);
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_random_tiles(input int n_items, input bit quiet);
      int          sent, tile_len, x0, y0, xspan, yspan, i;
      bit          noisy;
      logic [11:0] px, py;
      logic        tile_last;
      logic [15:0] lim;
      logic [12:0] w, h;
      w   = pick_extent();
      h   = pick_extent();
      lim = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2000))
                                         : 16'($urandom_range(0, 300));
      configure(lim, w, h);
      xspan   = (w > 4096) ? 4096 : w;
      yspan   = (h > 4096) ? 4096 : h;
      no_gaps = quiet;
      sent    = 0;
      while (sent < n_items) begin
         tile_len = $urandom_range(1, 8);
         x0       = $urandom_range(0, xspan - 1);
         y0       = $urandom_range(0, yspan - 1);
         noisy    = ($urandom_range(0, 7) == 0);
         for (i = 0; i < tile_len && sent < n_items; i++) begin
            // mostly a raster run inside the image, now and then a stray pixel
            if ($urandom_range(0, 9) == 0) begin
               px = 12'($urandom_range(0, 4095));
               py = 12'($urandom_range(0, 4095));
            end else begin
               px = 12'((x0 + i) % xspan);
               py = 12'(y0);
            end
            tile_last = noisy ? 1'($urandom_range(0, 1)) : (i == tile_len - 1);
            send_pixel(px, py, tile_last);
            sent++;
         end
      end
      no_gaps = 1'b0;
   endtask

   always @(posedge clock) begin : result_check
      pixel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_escapes.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, got count %0d tile_end %0b",
                     $time, rsp_iteration_count, rsp_tile_end);
         end else begin
            want = expected_escapes.pop_front();
            if (rsp_iteration_count !== want.count) begin
               error_count++;
               $display("%0t: iteration_count expected %0d, got %0d",
                        $time, want.count, rsp_iteration_count);
            end
            if (rsp_tile_end !== want.tile_end) begin
               error_count++;
               $display("%0t: tile_end expected %0b, got %0b",
                        $time, want.tile_end, rsp_tile_end);
            end
         end
         results_seen++;
         if (rsp_iteration_count > deepest_count) deepest_count = rsp_iteration_count;
         hold_left = no_gaps ? 0 : $urandom_range(0, 15);
      end
   end

   // receiver: hold off for the drawn number of cycles after each item
   always @(negedge clock) begin
      if (long_hold_req) begin
         hold_left     = LONG_HOLD;
         long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_pixel_x      = '0;
      req_pixel_y      = '0;
      req_last_in_tile = 1'b0;
      rsp_ready        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_MAX_ITER;
      csr_wdata        = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_zero_divisor();
      test_zero_limit();
      test_limit_extremes();
      test_output_stall();
      test_random_tiles(16, 1'b0);
      test_random_tiles(16, 1'b0);
      test_random_tiles(16, 1'b1);
      test_random_tiles(16, 1'b0);
      test_random_tiles(16, 1'b0);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d pixels under %0d register settings, checked %0d results, deepest %0d.",
               pixels_sent, settings_used, results_seen, deepest_count);
      $display("Took in zero divisors, zero and full limits, off-plane pixels, long output stall.");
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
